// ----- sv/mcd_pkg.sv -----
// ----------------------------------------------------------------------------
// mcd_pkg
// Shared types and constants of the media chunk deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package mcd_pkg;

  localparam int unsigned MAX_PACKET_BYTES_DEF = 65536;

  localparam int unsigned PKT_W  = 17;
  localparam int unsigned HDR_W  = 14;
  localparam int unsigned POS_W  = 48;
  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned CIDX_W = 8;

  localparam logic [15:0] TYPE_DATA  = 16'h4424;
  localparam logic [15:0] TYPE_END   = 16'h4524;
  localparam int unsigned CHUNK_HDR_BYTES = 12;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_PACKET_BYTES = 8'd0;
  localparam logic [CIDX_W-1:0] REG_HEADER_BYTES = 8'd1;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HALTED  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_DATA      = 3'd1,
    KIND_PAYLOAD   = 3'd2,
    KIND_STOP      = 3'd3,
    KIND_NEW       = 3'd4,
    KIND_BAD_TYPE  = 3'd5,
    KIND_BAD_LEN   = 3'd6,
    KIND_HALTED    = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         payload_byte;
    logic [SEQ_W-1:0]   chunk_seq;
    logic [POS_W-1:0]   position;
    logic [PKT_W-1:0]   pad_count;
    logic               payload_end;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/media_chunk_deframer.sv -----
// ----------------------------------------------------------------------------
// media_chunk_deframer
// Splits a byte stream of media chunks into headers, positions and payload.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis_*: one chunk-stream byte per word (tdata[7:0]).
//   m_axis_*: exactly one result word per input byte; tuser carries the kind,
//     tlast marks the end of a chunk payload, tdata carries payload byte,
//     sequence, packet position and pad count.
//   cfg_*: register writes (0 packet_bytes, 1 header_bytes), always ready;
//     write only while no byte is in flight.
// Output: a result is registered in the output stage, or in the skid stage while the receiver stalls.
// Throughput: one byte per cycle while the skid stage is empty, set by the single parser state update.
// Stall: s_axis_tready is a register; when the receiver stalls, one more
//   byte is taken into a skid stage and tready then drops until it drains.
// Reset: clears parser state, output valids and both config registers; the
//   parser starts in the header phase. A stop or an error halts the block
//   (every byte answers halted) until the next reset.
// ----------------------------------------------------------------------------
`default_nettype none

module media_chunk_deframer #(
  parameter int unsigned MAX_PACKET_BYTES = mcd_pkg::MAX_PACKET_BYTES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [7:0]                 s_axis_tdata,   // data_byte
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // payload_byte[7:0], chunk_seq[39:8], position[87:40], pad_count[104:88]
  output logic [111:0]                    m_axis_tdata,
  output logic [2:0]                      m_axis_tuser,   // kind
  output logic                            m_axis_tlast,   // payload_end
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [mcd_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [mcd_pkg::PKT_W-1:0]  cfg_data
);
  import mcd_pkg::*;

  logic [PKT_W-1:0] packet_bytes;
  logic [HDR_W-1:0] header_bytes;
  logic             accept;
  result_t          res_comb;
  result_t          res_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_bytes <= '0;
      header_bytes <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_PACKET_BYTES) begin
        packet_bytes <= cfg_data;
      end else if (cfg_index == REG_HEADER_BYTES) begin
        header_bytes <= cfg_data[HDR_W-1:0];
      end
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  mcd_parser #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (s_axis_tdata),
    .packet_bytes(packet_bytes),
    .header_bytes(header_bytes),
    .result      (res_comb)
  );

  mcd_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (res_comb),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (res_out)
  );

  assign m_axis_tuser = res_out.kind;
  assign m_axis_tlast = res_out.payload_end;
  assign m_axis_tdata = {7'd0, res_out.pad_count, res_out.position,
                         res_out.chunk_seq, res_out.payload_byte};

endmodule

`default_nettype wire

// ----- sv/mcd_parser.sv -----
// ----------------------------------------------------------------------------
// mcd_parser
// Chunk header parser and payload counter; forms one result per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mcd_parser #(
  parameter int unsigned MAX_PACKET_BYTES = mcd_pkg::MAX_PACKET_BYTES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      accept,
  input  wire logic [7:0]                data_byte,
  input  wire logic [mcd_pkg::PKT_W-1:0] packet_bytes,
  input  wire logic [mcd_pkg::HDR_W-1:0] header_bytes,
  output mcd_pkg::result_t               result
);
  import mcd_pkg::*;

  localparam logic [3:0] HDR_LAST = 4'(CHUNK_HDR_BYTES - 1);

  phase_t            phase, phase_next;
  logic [3:0]        hdr_count, hdr_count_next;
  logic [LEN_W-1:0]  chunk_kind, chunk_kind_next;
  logic [LEN_W-1:0]  payload_total, payload_total_next;
  logic [LEN_W-1:0]  payload_left, payload_left_next;
  logic [SEQ_W-1:0]  seq_num, seq_num_next;

  logic [PKT_W-1:0]       pkt;
  logic [SEQ_W+PKT_W-1:0] prod;
  logic [LEN_W-1:0]       total_less;
  logic [LEN_W-1:0]       left_dec;

  // packet length clamped to the largest supported packet
  assign pkt = (packet_bytes > PKT_W'(MAX_PACKET_BYTES)) ?
               PKT_W'(MAX_PACKET_BYTES) : packet_bytes;

  assign prod = (SEQ_W+PKT_W)'(seq_num) * (SEQ_W+PKT_W)'(pkt);

  assign total_less = payload_total - LEN_W'(8);
  assign left_dec   = payload_left - LEN_W'(1);

  always_comb begin
    phase_next         = phase;
    hdr_count_next     = hdr_count;
    chunk_kind_next    = chunk_kind;
    payload_total_next = payload_total;
    payload_left_next  = payload_left;
    seq_num_next       = seq_num;
    result             = '0;
    unique case (phase)
      PH_PAYLOAD: begin
        result.kind         = KIND_PAYLOAD;
        result.payload_byte = data_byte;
        result.chunk_seq    = seq_num;
        payload_left_next   = left_dec;
        if (left_dec == '0) begin
          result.payload_end = 1'b1;
          result.pad_count   = pkt - {1'b0, payload_total};
          phase_next         = PH_HEADER;
          hdr_count_next     = '0;
        end
      end
      PH_HEADER: begin
        case (hdr_count)
          4'd0: chunk_kind_next[7:0]     = data_byte;
          4'd1: chunk_kind_next[15:8]    = data_byte;
          4'd2: payload_total_next[7:0]  = data_byte;
          4'd3: payload_total_next[15:8] = data_byte;
          4'd4: seq_num_next[7:0]        = data_byte;
          4'd5: seq_num_next[15:8]       = data_byte;
          4'd6: seq_num_next[23:16]      = data_byte;
          4'd7: seq_num_next[31:24]      = data_byte;
          default: ;
        endcase
        if (hdr_count == HDR_LAST) begin
          hdr_count_next   = '0;
          result.chunk_seq = seq_num;
          if (chunk_kind == TYPE_DATA) begin
            if (payload_total < LEN_W'(8)) begin
              result.kind = KIND_BAD_LEN;
              phase_next  = PH_HALTED;
            end else if ({1'b0, total_less} > pkt) begin
              payload_total_next = total_less;
              result.kind        = KIND_BAD_LEN;
              phase_next         = PH_HALTED;
            end else begin
              payload_total_next = total_less;
              result.kind        = KIND_DATA;
              result.position    = POS_W'(header_bytes) + prod[POS_W-1:0];
              if (total_less == '0) begin
                result.payload_end = 1'b1;
                result.pad_count   = pkt;
              end else begin
                payload_left_next = total_less;
                phase_next        = PH_PAYLOAD;
              end
            end
          end else if (chunk_kind == TYPE_END) begin
            if (seq_num == '0) begin
              result.kind = KIND_STOP;
              phase_next  = PH_HALTED;
            end else begin
              // new stream: back to the state after reset
              result.kind        = KIND_NEW;
              phase_next         = PH_HEADER;
              chunk_kind_next    = '0;
              payload_total_next = '0;
              payload_left_next  = '0;
              seq_num_next       = '0;
            end
          end else begin
            result.kind = KIND_BAD_TYPE;
            phase_next  = PH_HALTED;
          end
        end else begin
          hdr_count_next = hdr_count + 4'd1;
        end
      end
      PH_HALTED: begin
        result.kind      = KIND_HALTED;
        result.chunk_seq = seq_num;
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      hdr_count     <= '0;
      chunk_kind    <= '0;
      payload_total <= '0;
      payload_left  <= '0;
      seq_num       <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      hdr_count     <= hdr_count_next;
      chunk_kind    <= chunk_kind_next;
      payload_total <= payload_total_next;
      payload_left  <= payload_left_next;
      seq_num       <= seq_num_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/mcd_out_buf.sv -----
// ----------------------------------------------------------------------------
// mcd_out_buf
// Result register with a skid stage so the input side sees a registered ready.
// ----------------------------------------------------------------------------
`default_nettype none

module mcd_out_buf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire mcd_pkg::result_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output mcd_pkg::result_t      out_data
);
  import mcd_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    load_out;

  assign in_ready = !skid_valid;
  assign load_out = out_ready || !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      out_valid  <= skid_valid || in_valid;
      skid_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= skid_valid ? skid_data : in_data;
    end
    if (!load_out && in_ready) begin
      skid_data <= in_data;
    end
  end

endmodule

`default_nettype wire
